// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge of clk, ignored while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- src/rpd_pkg.sv -----
package rpd_pkg;

  // Default sizes of the list memory and of the permutation counter.
  localparam int DEF_MAX_ITEMS = 64;
  localparam int DEF_MAX_PERMS = 256;

  // Field widths.
  localparam int RND_W          = 31;
  localparam int ITEM_OUT_W     = 6;
  localparam int POS_W          = 6;
  localparam int SLOT_W         = 10;
  localparam int SET_SIZE_W     = 7;
  localparam int PERM_TOTAL_W   = 9;
  localparam int FIRST_SLOT_W   = 9;
  localparam int CFG_DATA_W     = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int S_TDATA_W      = 32;
  localparam int M_TDATA_W      = 24;

  // Remainder unit: quotient bits retired per cycle and cycles per remainder.
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES     = (RND_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int DIV_BITS       = DIV_CYCLES * DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Register values after reset.
  localparam logic [SET_SIZE_W-1:0]   RST_SET_SIZE   = SET_SIZE_W'(64);
  localparam logic [PERM_TOTAL_W-1:0] RST_PERM_TOTAL = PERM_TOTAL_W'(1);
  localparam logic [FIRST_SLOT_W-1:0] RST_FIRST_SLOT = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_SIZE   = 2'd0,
    REG_PERM_TOTAL = 2'd1,
    REG_FIRST_SLOT = 2'd2
  } cfg_reg_t;

endpackage

// ----- src/rpd_ram.sv -----
module rpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rpd_mod.sv -----
`include "assert_macros.svh"

// Restoring remainder unit: several quotient bits per cycle, remainder only.
module rpd_mod #(
  parameter int W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpd_pkg::RND_W-1:0] dividend,
  input  logic [W-1:0]              divisor,
  output logic                      done,
  output logic [W-1:0]              rem
);
  import rpd_pkg::*;

  logic                    busy;
  logic [DIV_CNT_W-1:0]    cnt;
  logic [DIV_BITS-1:0]     dvd;
  logic [W-1:0]            dvs;
  logic [W-1:0]            rem_next;
  logic [DIV_BITS-1:0]     dvd_next;

  always_comb begin
    logic [W:0] t;
    rem_next = rem;
    dvd_next = dvd;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      t = {rem_next, dvd_next[DIV_BITS-1]};
      dvd_next = dvd_next << 1;
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
      end
      rem_next = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= DIV_BITS'(dividend);
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= dvd_next;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_CLK(a_rem_below_divisor, clk, rst, done |-> (dvs == '0 || rem < dvs), "remainder not reduced")

endmodule

// ----- src/random_permutation_drawer.sv -----
// Random permutation drawer. Each request on the input stream carries one random
// word; the block answers with one draw: the item at rank (word mod items left) of
// the ordered list of items not yet drawn in the current permutation, which is
// then removed. tlast marks the draw that completes a permutation, tuser the one
// that completes the final permutation of a run, after which a new run starts.
// A draw first runs the remainder unit, which retires four quotient bits a cycle,
// then reads the drawn entry; the removal moves the list entries behind the drawn
// item, one entry a cycle, through the single write port of the list memory. One
// draw is in work at a time; the input is ready again as soon as the result sits
// in the output register. Writing set_size or permutation_total restarts the run.
`include "assert_macros.svh"

module random_permutation_drawer #(
  parameter int MAX_ITEMS = rpd_pkg::DEF_MAX_ITEMS,
  parameter int MAX_PERMS = rpd_pkg::DEF_MAX_PERMS
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rpd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [30:0] random_value
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [5:0] drawn_item, [11:6] position, [21:12] slot
  output logic [rpd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // last_in_perm
  output logic                          m_axis_tuser   // last_of_all
);
  import rpd_pkg::*;

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int PC_W  = $clog2(MAX_PERMS + 1);
  localparam int SZ_W  = (CNT_W > SET_SIZE_W) ? CNT_W : SET_SIZE_W;
  localparam int TT_W  = (PC_W > PERM_TOTAL_W) ? PC_W : PERM_TOTAL_W;
  localparam int SUM_W = ((PC_W > FIRST_SLOT_W) ? PC_W : FIRST_SLOT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_FETCH,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                    state;
  logic [SET_SIZE_W-1:0]     set_size;
  logic [PERM_TOTAL_W-1:0]   permutation_total;
  logic [FIRST_SLOT_W-1:0]   first_slot;
  logic [CNT_W-1:0]          draw_count;
  logic [PC_W-1:0]           perm_count;
  logic [CNT_W-1:0]          low_mark;    // list entries below this still hold their index
  logic [CNT_W-1:0]          left_r;
  logic [AW-1:0]             rank_r;
  logic [AW-1:0]             item_r;
  logic [AW-1:0]             rd_ptr;
  logic [AW-1:0]             wr_ptr;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             ram_q;
  logic                      id_q;
  logic [AW-1:0]             id_addr_q;
  logic [AW-1:0]             list_q;
  logic                      ram_we;
  logic                      mod_done;
  logic [CNT_W-1:0]          mod_rem;
  logic [AW-1:0]             mod_rank;
  logic [CNT_W-1:0]          n_eff;
  logic [PC_W-1:0]           total_eff;
  logic [SZ_W-1:0]           size_ext;
  logic [TT_W-1:0]           total_ext;
  logic                      in_acc;
  logic                      out_free;
  logic                      end_perm;
  logic                      end_all;
  logic [SUM_W-1:0]          slot_sum;

  // Effective set size and run length after clamping.
  always_comb begin
    size_ext  = SZ_W'(set_size);
    total_ext = TT_W'(permutation_total);
    if (size_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (size_ext > SZ_W'(MAX_ITEMS)) begin
      n_eff = CNT_W'(MAX_ITEMS);
    end else begin
      n_eff = CNT_W'(size_ext);
    end
    if (total_ext == '0) begin
      total_eff = PC_W'(1);
    end else if (total_ext > TT_W'(MAX_PERMS)) begin
      total_eff = PC_W'(MAX_PERMS);
    end else begin
      total_eff = PC_W'(total_ext);
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign mod_rank      = AW'(mod_rem);
  assign end_perm      = (draw_count + 1'b1) == n_eff;
  assign end_all       = end_perm && ((perm_count + 1'b1) == total_eff);
  assign slot_sum      = SUM_W'(first_slot) + SUM_W'(perm_count);

  rpd_mod #(
    .W (CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .dividend (s_axis_tdata[RND_W-1:0]),
    .divisor  (n_eff - draw_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // List memory; entries below low_mark read as their own index.
  assign raddr  = (state == S_DIV) ? mod_rank : rd_ptr;
  assign ram_we = (state == S_SHIFT);
  assign list_q = id_q ? id_addr_q : ram_q;

  rpd_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_ITEMS)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (list_q),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    id_q      <= CNT_W'(raddr) < low_mark;
    id_addr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      set_size          <= RST_SET_SIZE;
      permutation_total <= RST_PERM_TOTAL;
      first_slot        <= RST_FIRST_SLOT;
      draw_count        <= '0;
      perm_count        <= '0;
      low_mark          <= CNT_W'(MAX_ITEMS);
      m_axis_tvalid     <= 1'b0;
    end else begin
      // A result leaving while the next one is loaded is handled in S_DONE.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_SET_SIZE: begin
            set_size   <= SET_SIZE_W'(cfg_data);
            draw_count <= '0;
            perm_count <= '0;
            low_mark   <= CNT_W'(MAX_ITEMS);
          end
          REG_PERM_TOTAL: begin
            permutation_total <= PERM_TOTAL_W'(cfg_data);
            draw_count        <= '0;
            perm_count        <= '0;
            low_mark          <= CNT_W'(MAX_ITEMS);
          end
          REG_FIRST_SLOT: begin
            first_slot <= FIRST_SLOT_W'(cfg_data);
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            left_r <= n_eff - draw_count;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          // The read of the drawn entry goes out in the cycle the remainder shows.
          if (mod_done) begin
            rank_r <= mod_rank;
            rd_ptr <= mod_rank + 1'b1;
            state  <= S_FETCH;
          end
        end
        S_FETCH: begin
          item_r <= list_q;
          wr_ptr <= rank_r;
          rd_ptr <= rd_ptr + 1'b1;
          if ((CNT_W'(rank_r) + 1'b1) < left_r) begin
            state <= S_SHIFT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          // Each cycle one entry moves down by one place behind the drawn item.
          wr_ptr <= wr_ptr + 1'b1;
          rd_ptr <= rd_ptr + 1'b1;
          if ((CNT_W'(wr_ptr) + CNT_W'(2)) == left_r) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= M_TDATA_W'({SLOT_W'(slot_sum), POS_W'(draw_count),
                                         ITEM_OUT_W'(item_r)});
            m_axis_tlast  <= end_perm;
            m_axis_tuser  <= end_all;
            if (end_perm) begin
              draw_count <= '0;
              low_mark   <= CNT_W'(MAX_ITEMS);
              perm_count <= end_all ? '0 : perm_count + 1'b1;
            end else begin
              draw_count <= draw_count + 1'b1;
              if (CNT_W'(rank_r) < low_mark) begin
                low_mark <= CNT_W'(rank_r);
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_one_draw_at_a_time, clk, rst, in_acc |=> !s_axis_tready, "input taken while busy")
  `ASSERT_CLK(a_final_ends_perm, clk, rst, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "final draw without end of permutation")
  `ASSERT_CLK(a_shift_in_range, clk, rst, (state == S_SHIFT) |-> ((CNT_W'(wr_ptr) + CNT_W'(2)) <= left_r), "list move past live entries")

endmodule
